>>> src/earliest_free_server_dispatch_defines.svh
// Assertion macros for the earliest-free-server dispatch block
`ifndef EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define EFSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("efsd: same-cycle check failed");

// Next-cycle implication, masked while reset is asserted
`define EFSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("efsd: next-cycle check failed");

// Check on the cycle after reset is sampled low
`define EFSD_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("efsd: post-reset check failed");

`endif

>>> src/efsd_pkg.sv
// Shared constants, command/status types and helpers for the dispatch block
`timescale 1ns / 1ps
`default_nettype none

package efsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int DUR_W       = 16;
    localparam int SRV_W       = 5;
    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Controller to datapath
    typedef struct packed {
        logic fill;        // place job directly on the next unfilled server
        logic scan_start;  // capture job and set up a scan pass
        logic scan;        // scan pass active
        logic finish;      // commit pick and pending subtraction
        logic load_out;    // move result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fill_phase;
        logic scan_done;
        logic out_free;
    } t_status;

    // Clamp the register value to 1..MAX_SERVERS
    function automatic logic [CNT_W-1:0] eff_servers(input logic [CFG_W-1:0] cfg);
        if (cfg == '0) begin
            return CNT_W'(1);
        end else if (int'(cfg) > MAX_SERVERS) begin
            return CNT_W'(MAX_SERVERS);
        end else begin
            return CNT_W'(cfg);
        end
    endfunction

endpackage

`default_nettype wire

>>> src/efsd_ctl.sv
// Controller state machine for the dispatch block
`timescale 1ns / 1ps
`default_nettype none

module efsd_ctl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire efsd_pkg::t_status i_status,
    output logic                  o_stall,
    output efsd_pkg::t_cmd        o_cmd
);
    import efsd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_status.fill_phase) begin
                        o_cmd.fill = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> src/efsd_dp.sv
// Datapath: remaining-work memory, scan pipeline, minimum tracker, output register
`timescale 1ns / 1ps
`default_nettype none

module efsd_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [efsd_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [efsd_pkg::DUR_W-1:0]    i_job_duration,
    input  wire logic                          i_stall,
    input  wire efsd_pkg::t_cmd                i_cmd,
    output efsd_pkg::t_status                  o_status,
    output logic                               o_valid,
    output logic [efsd_pkg::SRV_W-1:0]         o_server_number
);
    import efsd_pkg::*;

    // Remaining work per server; entries are meaningful only once written
    logic [DUR_W-1:0] r_mem [MAX_SERVERS];

    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_jobs_seen;
    logic [CNT_W-1:0] n_eff;

    logic [DUR_W-1:0] r_dur;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_m;
    logic [CNT_W-1:0] r_rd_k;
    logic             r_dv;
    logic [IDX_W-1:0] r_dv_idx;
    logic [DUR_W-1:0] r_mem_q;
    logic [DUR_W-1:0] r_min;
    logic [IDX_W-1:0] r_pick;

    // Subtraction left over from the previous dispatch, applied lazily on the next scan
    logic [CNT_W-1:0] r_pend_n;
    logic [DUR_W-1:0] r_pend_least;
    logic [IDX_W-1:0] r_pend_pick;

    logic [SRV_W-1:0] r_result;
    logic             r_o_valid;
    logic [SRV_W-1:0] r_o_srv;

    logic             rd_en;
    logic [DUR_W-1:0] adj;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [DUR_W-1:0] mem_wdata;
    logic             out_free;

    assign n_eff    = eff_servers(r_cfg);
    assign rd_en    = i_cmd.scan && (r_rd_k < r_m);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        if ((CNT_W'(r_dv_idx) < r_pend_n) && (r_dv_idx != r_pend_pick)) begin
            adj = r_mem_q - r_pend_least;
        end else begin
            adj = r_mem_q;
        end
    end

    // Single write port: fill, scan write-back and finish never overlap
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dv_idx;
        mem_wdata = adj;
        if (i_cmd.fill) begin
            mem_we    = 1'b1;
            mem_waddr = r_jobs_seen[IDX_W-1:0];
            mem_wdata = i_job_duration;
        end else if (i_cmd.finish) begin
            mem_we    = 1'b1;
            mem_waddr = r_pick;
            mem_wdata = r_dur;
        end else if (i_cmd.scan && r_dv) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_k[IDX_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_jobs_seen <= '0;
            r_pend_n    <= '0;
            r_dv        <= 1'b0;
            r_rd_k      <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.fill) begin
                r_jobs_seen <= r_jobs_seen + CNT_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_rd_k <= '0;
                r_dv   <= 1'b0;
            end else if (i_cmd.scan) begin
                r_dv <= rd_en;
                if (rd_en) begin
                    r_rd_k <= r_rd_k + CNT_W'(1);
                end
            end else begin
                r_dv <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_pend_n <= r_n;
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_dur <= i_job_duration;
            r_n   <= n_eff;
            r_m   <= (n_eff > r_pend_n) ? n_eff : r_pend_n;
        end
        if (i_cmd.scan && rd_en) begin
            r_dv_idx <= r_rd_k[IDX_W-1:0];
        end
        // track the least remaining work among the servers in use, lowest index on a tie
        if (i_cmd.scan && r_dv && (CNT_W'(r_dv_idx) < r_n)) begin
            if ((r_dv_idx == '0) || (adj < r_min)) begin
                r_min  <= adj;
                r_pick <= r_dv_idx;
            end
        end
        if (i_cmd.fill) begin
            r_result <= SRV_W'(r_jobs_seen + CNT_W'(1));
        end
        if (i_cmd.finish) begin
            r_pend_least <= r_min;
            r_pend_pick  <= r_pick;
            r_result     <= SRV_W'(CNT_W'(r_pick) + CNT_W'(1));
        end
        if (i_cmd.load_out) begin
            r_o_srv <= r_result;
        end
    end

    assign o_status.fill_phase = (r_jobs_seen < n_eff);
    assign o_status.scan_done  = r_dv && (CNT_W'(r_dv_idx) == (r_m - CNT_W'(1)));
    assign o_status.out_free   = out_free;

    assign o_valid         = r_o_valid;
    assign o_server_number = r_o_srv;

endmodule

`default_nettype wire

>>> src/earliest_free_server_dispatch.sv
// Earliest-free-server dispatch: top level
//
// Input channel: i_valid / o_stall with i_job_duration (16-bit unsigned).
// A transaction is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_server_number (1..16).
// Configuration: i_cfg_we writes i_cfg_data into the server count; write
// only while no job is in flight. A count of 0 acts as 1, above 16 as 16.
// Jobs are handled one at a time. While servers are still being filled a
// job is placed directly on the next unfilled server. Otherwise the
// block scans the remaining-work memory one entry per cycle through its
// single read port, covering M entries, where M is the larger of the
// current server count and the count at the previous scan. The result
// is then loaded into the output register, and the next job can be
// taken in the cycle after the load.
// Reset clears the job counter, the pending subtraction and the output
// valid, and sets the server count to 16. While the receiver stalls, the
// result is held and a finished job waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "earliest_free_server_dispatch_defines.svh"

module earliest_free_server_dispatch (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [efsd_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [efsd_pkg::DUR_W-1:0]    i_job_duration,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [efsd_pkg::SRV_W-1:0]         o_server_number
);
    import efsd_pkg::*;

    t_cmd    cmd;
    t_status status;

    efsd_ctl u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    efsd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_job_duration  (i_job_duration),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_server_number (o_server_number)
    );

    `EFSD_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `EFSD_ASSERT_IMP(a_srv_range, o_valid, (o_server_number - SRV_W'(1)) < SRV_W'(MAX_SERVERS))
    `EFSD_ASSERT_RST(a_idle_after_reset, !o_stall && !o_valid)

endmodule

`default_nettype wire
